@@ rtl/obrb_pkg.sv @@
// Shared types and constants for the overwriting byte ring buffer.
// Used by obrb_front, obrb_cmd_fifo, obrb_back and the top level.
// Depends on nothing else.
`timescale 1ns / 1ps

package obrb_pkg;

  localparam int BYTE_W        = 8;
  localparam int FUNC_W        = 3;
  localparam int COUNT_W       = 7;
  // Widest store index, for the largest supported depth of 64.
  localparam int ADDR_W        = 6;
  localparam int DEPTH_DEFAULT = 64;
  localparam int CMDQ_DEPTH    = 4;
  localparam int CMDQ_PTR_W    = $clog2(CMDQ_DEPTH);

  // Operation codes carried by an input item.
  typedef enum logic [FUNC_W-1:0] {
    OP_PUSH       = 3'd0,
    OP_POP        = 3'd1,
    OP_PEEK_FRONT = 3'd2,
    OP_PEEK_BACK  = 3'd3,
    OP_SKIP       = 3'd4,
    OP_CLEAR      = 3'd5
  } op_t;

  // What the back end does with a queued command.
  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_EMPTY = 2'd2
  } cmd_kind_t;

  // One classified operation, with the status it reports.
  typedef struct packed {
    cmd_kind_t          kind;
    logic [BYTE_W-1:0]  data;
    logic [ADDR_W-1:0]  addr;
    logic [COUNT_W-1:0] granted;
    logic               dropped;
    logic [COUNT_W-1:0] fill;
  } cmd_t;

endpackage

@@ rtl/obrb_front.sv @@
// Front end of the ring buffer: accepts items, owns the pointers and the
// fill level, and turns each item into one queued command.
// Depends on obrb_pkg.
`timescale 1ns / 1ps

module obrb_front #(
  parameter int DEPTH = obrb_pkg::DEPTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [obrb_pkg::FUNC_W-1:0]  func,
  input  logic [obrb_pkg::BYTE_W-1:0]  data_in,
  input  logic [obrb_pkg::COUNT_W-1:0] count,
  input  logic                         q_full,
  output logic                         q_push,
  output obrb_pkg::cmd_t               q_cmd
);

  import obrb_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);

  logic [PTR_W-1:0]   write_pointer, write_pointer_next;
  logic [PTR_W-1:0]   read_pointer, read_pointer_next;
  logic [COUNT_W-1:0] fill_count, fill_count_next;
  logic [COUNT_W-1:0] grant;
  logic [COUNT_W-1:0] wp_ext;
  logic [PTR_W-1:0]   back_start;
  logic               accept;
  logic               full;

  // Add with wrap at DEPTH; the sum never reaches twice DEPTH.
  function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] p,
                                                input logic [COUNT_W-1:0] n);
    logic [COUNT_W-1:0] s;
    s = COUNT_W'(p) + n;
    if (s >= COUNT_W'(DEPTH)) begin
      s = s - COUNT_W'(DEPTH);
    end
    return s[PTR_W-1:0];
  endfunction

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept;
  assign full     = (fill_count == COUNT_W'(DEPTH));

  // Requested count cut to the fill level.
  assign grant = (count < fill_count) ? count : fill_count;

  // Oldest of the newest grant bytes: write pointer minus grant, wrapped.
  assign wp_ext = COUNT_W'(write_pointer);
  always_comb begin
    if (wp_ext >= grant) begin
      back_start = PTR_W'(wp_ext - grant);
    end else begin
      back_start = PTR_W'(wp_ext + COUNT_W'(DEPTH) - grant);
    end
  end

  // Classify the item and work out the pointer updates.
  always_comb begin
    write_pointer_next = write_pointer;
    read_pointer_next  = read_pointer;
    fill_count_next    = fill_count;
    q_cmd.kind         = CMD_EMPTY;
    q_cmd.data         = data_in;
    q_cmd.addr         = ADDR_W'(read_pointer);
    q_cmd.granted      = '0;
    q_cmd.dropped      = 1'b0;
    unique case (op_t'(func))
      OP_PUSH: begin
        q_cmd.kind         = CMD_WRITE;
        q_cmd.addr         = ADDR_W'(write_pointer);
        q_cmd.granted      = COUNT_W'(1);
        write_pointer_next = wrap_add(write_pointer, COUNT_W'(1));
        if (full) begin
          read_pointer_next = wrap_add(read_pointer, COUNT_W'(1));
          q_cmd.dropped     = 1'b1;
        end else begin
          fill_count_next = fill_count + COUNT_W'(1);
        end
      end
      OP_POP: begin
        q_cmd.kind        = (grant != '0) ? CMD_READ : CMD_EMPTY;
        q_cmd.granted     = grant;
        read_pointer_next = wrap_add(read_pointer, grant);
        fill_count_next   = fill_count - grant;
      end
      OP_PEEK_FRONT: begin
        q_cmd.kind    = (grant != '0) ? CMD_READ : CMD_EMPTY;
        q_cmd.granted = grant;
      end
      OP_PEEK_BACK: begin
        q_cmd.kind    = (grant != '0) ? CMD_READ : CMD_EMPTY;
        q_cmd.addr    = ADDR_W'(back_start);
        q_cmd.granted = grant;
      end
      OP_SKIP: begin
        q_cmd.granted     = grant;
        read_pointer_next = wrap_add(read_pointer, grant);
        fill_count_next   = fill_count - grant;
      end
      OP_CLEAR: begin
        write_pointer_next = '0;
        read_pointer_next  = '0;
        fill_count_next    = '0;
      end
      default: begin
        // Unused codes change nothing and report an empty result.
      end
    endcase
    q_cmd.fill = fill_count_next;
  end

  // Pointer and fill registers move only on an accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer <= '0;
      read_pointer  <= '0;
      fill_count    <= '0;
    end else if (accept) begin
      write_pointer <= write_pointer_next;
      read_pointer  <= read_pointer_next;
      fill_count    <= fill_count_next;
    end
  end

endmodule

@@ rtl/obrb_cmd_fifo.sv @@
// Short command queue between the front and back ends of the ring buffer.
// Register based, head entry always visible to the reader.
// Depends on obrb_pkg.
`timescale 1ns / 1ps

module obrb_cmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  obrb_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output obrb_pkg::cmd_t head,
  output logic           empty
);

  import obrb_pkg::*;

  cmd_t                  entries [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr;
  logic [CMDQ_PTR_W-1:0] rd_ptr;
  logic [CMDQ_PTR_W:0]   used;

  assign full  = (used == (CMDQ_PTR_W + 1)'(CMDQ_DEPTH));
  assign empty = (used == '0);
  assign head  = entries[rd_ptr];

  // Storage for queued commands.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      used   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + CMDQ_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + CMDQ_PTR_W'(1);
      end
      if (push && !pop) begin
        used <= used + (CMDQ_PTR_W + 1)'(1);
      end else if (pop && !push) begin
        used <= used - (CMDQ_PTR_W + 1)'(1);
      end
    end
  end

endmodule

@@ rtl/obrb_back.sv @@
// Back end of the ring buffer: holds the byte store, carries out queued
// commands in order and drives the registered result channel.
// Depends on obrb_pkg.
`timescale 1ns / 1ps

module obrb_back #(
  parameter int DEPTH = obrb_pkg::DEPTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  obrb_pkg::cmd_t               head,
  input  logic                         q_empty,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [obrb_pkg::BYTE_W-1:0]  data_out,
  output logic                         data_valid,
  output logic                         last,
  output logic                         dropped,
  output logic [obrb_pkg::COUNT_W-1:0] granted_count,
  output logic [obrb_pkg::COUNT_W-1:0] fill_level,
  output logic [obrb_pkg::COUNT_W-1:0] free_space
);

  import obrb_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);

  logic [BYTE_W-1:0]  byte_store [DEPTH];
  logic [BYTE_W-1:0]  rd_data;
  logic [COUNT_W-1:0] idx;
  logic [PTR_W-1:0]   cur_addr;
  logic [PTR_W-1:0]   rd_addr;
  logic [PTR_W-1:0]   rd_addr_inc;
  logic               issue;
  logic               is_read;
  logic               is_last_byte;
  logic               cmd_done;

  // A result can be issued when the output register is free or draining.
  assign issue   = !q_empty && (!out_valid || !out_stall);
  assign is_read = (head.kind == CMD_READ);

  // First byte starts at the command's address, later ones follow on.
  assign rd_addr      = (idx == '0) ? head.addr[PTR_W-1:0] : cur_addr;
  assign rd_addr_inc  = (rd_addr == PTR_W'(DEPTH - 1)) ? '0 : rd_addr + PTR_W'(1);
  assign is_last_byte = ((idx + COUNT_W'(1)) == head.granted);
  assign cmd_done     = !is_read || is_last_byte;
  assign q_pop        = issue && cmd_done;

  // Byte store: one write port for pushes, one registered read port.
  always_ff @(posedge clk) begin
    if (issue && head.kind == CMD_WRITE) begin
      byte_store[head.addr[PTR_W-1:0]] <= head.data;
    end
    if (issue && is_read) begin
      rd_data <= byte_store[rd_addr];
    end
  end

  // Byte position within the current read command.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx      <= '0;
      cur_addr <= '0;
    end else if (issue && is_read) begin
      cur_addr <= rd_addr_inc;
      idx      <= is_last_byte ? '0 : idx + COUNT_W'(1);
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= issue || (out_valid && out_stall);
    end
  end

  // Result status fields, loaded with each issued result.
  always_ff @(posedge clk) begin
    if (issue) begin
      data_valid    <= is_read;
      last          <= cmd_done;
      dropped       <= head.dropped;
      granted_count <= head.granted;
      fill_level    <= head.fill;
    end
  end

  assign data_out   = data_valid ? rd_data : '0;
  assign free_space = COUNT_W'(DEPTH) - fill_level;

endmodule

@@ rtl/overwriting_byte_ring_buffer.sv @@
// Top level of the overwriting byte ring buffer.
// Instantiates obrb_front, obrb_cmd_fifo and obrb_back; depends on obrb_pkg.
//
//   Channel   Handshake              Fields
//   input     in_valid / in_stall    func, data_in, count
//   output    out_valid / out_stall  data_out, data_valid, last, dropped,
//                                    granted_count, fill_level, free_space
//
// The front end takes one item per cycle while the four-entry command queue
// has room. Push, skip, clear and empty reads give one result each; a read
// of g bytes gives g results, one per byte, through the single read port
// of the byte store. Items pass through the command queue and the result
// register. Reset clears the pointers, the fill level, the queue and the
// output flag; the byte store is not cleared. Output stalls hold the result
// register and back up into the queue, which then stalls the input.
`timescale 1ns / 1ps

module overwriting_byte_ring_buffer #(
  parameter int DEPTH = obrb_pkg::DEPTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [obrb_pkg::FUNC_W-1:0]  func,
  input  logic [obrb_pkg::BYTE_W-1:0]  data_in,
  input  logic [obrb_pkg::COUNT_W-1:0] count,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [obrb_pkg::BYTE_W-1:0]  data_out,
  output logic                         data_valid,
  output logic                         last,
  output logic                         dropped,
  output logic [obrb_pkg::COUNT_W-1:0] granted_count,
  output logic [obrb_pkg::COUNT_W-1:0] fill_level,
  output logic [obrb_pkg::COUNT_W-1:0] free_space
);

  import obrb_pkg::*;

  cmd_t q_cmd;
  cmd_t q_head;
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;

  // Item acceptance and classification.
  obrb_front #(
    .DEPTH (DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .func     (func),
    .data_in  (data_in),
    .count    (count),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  // Command queue between the two halves.
  obrb_cmd_fifo u_cmd_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  // Store access and result generation.
  obrb_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (q_head),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .data_out      (data_out),
    .data_valid    (data_valid),
    .last          (last),
    .dropped       (dropped),
    .granted_count (granted_count),
    .fill_level    (fill_level),
    .free_space    (free_space)
  );

endmodule
